>>> hdl/erfp_pkg.sv
// Shared types, widths and floating-point constants for the ENDF real field parser.
package erfp_pkg;

    localparam int MAN_W       = 53;
    localparam int EXP_W       = 10;
    localparam int CNT_W       = 4;
    localparam int DIG_W       = 9;
    localparam int FRAC_DIGITS = 6;
    localparam int FINT_W      = 26;
    localparam int FMAG_W      = 25;
    localparam int FLZ_W       = $clog2(FMAG_W + 1);
    localparam int FIX_FRAC    = 72;
    localparam int E6_SHIFT    = 20;
    localparam int FFIX_W      = MAN_W + 24;
    localparam int SUM_W       = 82;
    localparam int MAG_W       = SUM_W - 1;
    localparam int MLZ_W       = $clog2(MAG_W + 1);
    localparam int STEPS       = 9;
    localparam int EXP_BIAS    = 1023;
    localparam int DBL_EXP_W   = 11;
    localparam int DBL_FRAC_W  = 52;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Constant operands: unbiased exponent and mantissa with hidden bit.
    localparam logic signed [EXP_W-1:0] E6_EXP    = -EXP_W'(20);
    localparam logic [MAN_W-1:0]        E6_MAN    = 53'h10C6F7A0B5ED8D;
    localparam logic signed [EXP_W-1:0] TEN_EXP   = EXP_W'(3);
    localparam logic [MAN_W-1:0]        TEN_MAN   = 53'h14000000000000;
    localparam logic signed [EXP_W-1:0] TENTH_EXP = -EXP_W'(4);
    localparam logic [MAN_W-1:0]        TENTH_MAN = 53'h1999999999999A;

    typedef struct packed {
        logic [7:0]  sign_char;
        logic [7:0]  lead_digit_char;
        logic [47:0] fraction_chars;
        logic [7:0]  exp_sign_char;
        logic [7:0]  exp_digit_char;
    } field_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        format_error;
    } result_t;

    // Normal double: value = man * 2^(exp - 52); zero flagged separately.
    typedef struct packed {
        logic                    sgn;
        logic                    zero;
        logic signed [EXP_W-1:0] exp;
        logic [MAN_W-1:0]        man;
    } fp_t;

    // Per-transaction sideband carried down the pipeline.
    typedef struct packed {
        logic                    neg;
        logic                    err;
        logic                    up;
        logic [CNT_W-1:0]        count;
        logic signed [DIG_W-1:0] lead;
    } tag_t;

endpackage

>>> hdl/erfp_fmul.sv
// Three-stage double multiplier by a positive constant, round to nearest even, with bypass.
module erfp_fmul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    input  erfp_pkg::fp_t                     a,
    input  logic signed [erfp_pkg::EXP_W-1:0] b_exp,
    input  logic [erfp_pkg::MAN_W-1:0]        b_man,
    input  logic                              bypass,
    input  erfp_pkg::tag_t                    tag,
    output logic                              prod_valid,
    output erfp_pkg::fp_t                     prod,
    output erfp_pkg::tag_t                    prod_tag
);
    import erfp_pkg::*;

    localparam int LO_W   = MAN_W / 2;
    localparam int HI_W   = MAN_W - LO_W;
    localparam int PROD_W = 2 * MAN_W;

    // stage 1: partial products
    logic [HI_W-1:0]        a_hi, b_hi;
    logic [LO_W-1:0]        a_lo, b_lo;
    logic [2*HI_W-1:0]      hh_next, hh_reg;
    logic [HI_W+LO_W-1:0]   hl_next, hl_reg, lh_next, lh_reg;
    logic [2*LO_W-1:0]      ll_next, ll_reg;
    logic signed [EXP_W-1:0] e1_reg, e2_reg;
    fp_t                    a1_reg, a2_reg;
    logic                   byp1_reg, byp2_reg;
    tag_t                   tag1_reg, tag2_reg;
    logic                   v1_reg, v2_reg, v3_reg;

    assign a_hi    = a.man[MAN_W-1:LO_W];
    assign a_lo    = a.man[LO_W-1:0];
    assign b_hi    = b_man[MAN_W-1:LO_W];
    assign b_lo    = b_man[LO_W-1:0];
    assign hh_next = (2*HI_W)'(a_hi) * (2*HI_W)'(b_hi);
    assign hl_next = (HI_W+LO_W)'(a_hi) * (HI_W+LO_W)'(b_lo);
    assign lh_next = (HI_W+LO_W)'(a_lo) * (HI_W+LO_W)'(b_hi);
    assign ll_next = (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);

    // stage 2: full product
    logic [PROD_W-1:0] p_next, p_reg;
    assign p_next = (PROD_W'(hh_reg) << (2*LO_W)) + (PROD_W'(hl_reg) << LO_W)
                  + (PROD_W'(lh_reg) << LO_W) + PROD_W'(ll_reg);

    // stage 3: normalize and round
    logic             top, g, s, inc, ovf;
    logic [MAN_W-1:0] man_sel;
    logic [MAN_W:0]   man_rnd;
    fp_t              prod_next, prod_reg;
    tag_t             tag3_reg;

    always_comb
    begin
        top     = p_reg[PROD_W-1];
        man_sel = top ? p_reg[PROD_W-1 -: MAN_W] : p_reg[PROD_W-2 -: MAN_W];
        g       = top ? p_reg[MAN_W-1] : p_reg[MAN_W-2];
        s       = top ? (|p_reg[MAN_W-2:0]) : (|p_reg[MAN_W-3:0]);
        inc     = g & (s | man_sel[0]);
        man_rnd = (MAN_W+1)'(man_sel) + (MAN_W+1)'(inc);
        ovf     = man_rnd[MAN_W];
        if (byp2_reg)
        begin
            prod_next = a2_reg;
        end
        else if (a2_reg.zero)
        begin
            prod_next = '{sgn: a2_reg.sgn, zero: 1'b1, exp: '0, man: '0};
        end
        else
        begin
            prod_next.sgn  = a2_reg.sgn;
            prod_next.zero = 1'b0;
            prod_next.exp  = e2_reg + EXP_W'(top) + EXP_W'(ovf);
            prod_next.man  = ovf ? man_rnd[MAN_W:1] : man_rnd[MAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hh_reg   <= hh_next;
        hl_reg   <= hl_next;
        lh_reg   <= lh_next;
        ll_reg   <= ll_next;
        e1_reg   <= a.exp + b_exp;
        a1_reg   <= a;
        byp1_reg <= bypass;
        tag1_reg <= tag;
        p_reg    <= p_next;
        e2_reg   <= e1_reg;
        a2_reg   <= a1_reg;
        byp2_reg <= byp1_reg;
        tag2_reg <= tag1_reg;
        prod_reg <= prod_next;
        tag3_reg <= tag2_reg;
    end

    assign prod_valid = v3_reg;
    assign prod       = prod_reg;
    assign prod_tag   = tag3_reg;

endmodule

>>> hdl/endf_real_field_parse.sv
// Top level: 11-column ENDF real field to IEEE double, fully pipelined.
module endf_real_field_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  erfp_pkg::field_t   field,
    output logic               done,
    output erfp_pkg::result_t  result
);
    // One transaction is taken on every clock where start is high; busy is
    // never raised because the pipeline has no stall. Each result appears on
    // result with done high for a single cycle, after the input register,
    // digit decode, integer conversion, the 1.0E-6 multiply and the exact
    // add of the units digit, then nine three-stage multiplier steps for the
    // exponent, then the output register. Results leave in order. Each
    // exponent step multiplies by 10.0 / 0.1 or passes the value through, so
    // latency does not depend on the exponent digit. Non-digit characters in
    // the digit columns set format_error; their code minus '0' is still used
    // as the digit weight, and the exponent count is clamped to 0..9.
    import erfp_pkg::*;

    localparam int LATENCY = 13 + 3 * STEPS + 1;

    localparam logic signed [FINT_W-1:0] FRAC_WEIGHT [FRAC_DIGITS] = '{
        FINT_W'(100000), FINT_W'(10000), FINT_W'(1000),
        FINT_W'(100), FINT_W'(10), FINT_W'(1)
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic signed [DIG_W-1:0] char_val(input logic [7:0] c);
        return $signed({1'b0, c}) - $signed(DIG_W'(CH_ZERO));
    endfunction

    function automatic logic [FLZ_W-1:0] lzc_small(input logic [FMAG_W-1:0] v);
        logic [FLZ_W-1:0] n;
        n = FLZ_W'(FMAG_W);
        for (int i = 0; i < FMAG_W; i++)
        begin
            if (v[i])
            begin
                n = FLZ_W'(FMAG_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [MLZ_W-1:0] lzc_wide(input logic [MAG_W-1:0] v);
        logic [MLZ_W-1:0] n;
        n = MLZ_W'(MAG_W);
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                n = MLZ_W'(MAG_W - 1 - i);
            end
        end
        return n;
    endfunction

    assign busy = 1'b0;

    // ---- S0: input register
    logic   v0_reg;
    field_t fld0_reg;

    // ---- S1: digit decode, fraction integer
    logic signed [FINT_W-1:0] fint_next, fint1_reg;
    logic                     ferr;
    tag_t                     tag1_next, tag1_reg;
    logic                     v1_reg;

    always_comb
    begin
        logic [7:0] c;
        logic [7:0] ed;
        fint_next = '0;
        ferr      = 1'b0;
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            c = fld0_reg.fraction_chars[8*(FRAC_DIGITS-1-i) +: 8];
            if (!is_digit(c))
            begin
                ferr = 1'b1;
            end
            fint_next = fint_next + FINT_W'(char_val(c)) * FRAC_WEIGHT[i];
        end
        ed             = fld0_reg.exp_digit_char;
        tag1_next.neg  = (fld0_reg.sign_char == CH_MINUS);
        tag1_next.up   = (fld0_reg.exp_sign_char == CH_PLUS);
        tag1_next.err  = ferr | !is_digit(fld0_reg.lead_digit_char) | !is_digit(ed);
        tag1_next.lead = char_val(fld0_reg.lead_digit_char);
        if (ed < CH_ZERO)
        begin
            tag1_next.count = '0;
        end
        else if (ed > CH_NINE)
        begin
            tag1_next.count = CNT_W'(STEPS);
        end
        else
        begin
            tag1_next.count = CNT_W'(ed - CH_ZERO);
        end
    end

    // ---- S2: magnitude and leading-zero count
    logic                     fsgn_next, fsgn2_reg;
    logic [FINT_W-1:0]        fabs;
    logic [FMAG_W-1:0]        fmag_next, fmag2_reg;
    logic [FLZ_W-1:0]         flz2_reg;
    tag_t                     tag2_reg;
    logic                     v2_reg;

    assign fsgn_next = fint1_reg[FINT_W-1];
    assign fabs      = fsgn_next ? FINT_W'(-fint1_reg) : FINT_W'(fint1_reg);
    assign fmag_next = fabs[FMAG_W-1:0];

    // ---- S3: integer to double (exact)
    fp_t              f0_next, f0_reg;
    logic [FMAG_W-1:0] fsh;
    tag_t             tag3_reg;
    logic             v3_reg;

    always_comb
    begin
        fsh          = fmag2_reg << flz2_reg;
        f0_next.sgn  = fsgn2_reg;
        f0_next.zero = (fmag2_reg == '0);
        f0_next.exp  = EXP_W'(FMAG_W - 1) - EXP_W'(flz2_reg);
        f0_next.man  = MAN_W'(fsh) << (MAN_W - FMAG_W);
    end

    // ---- fraction * 1.0E-6
    fp_t  f1;
    tag_t tag4;
    logic v4;

    erfp_fmul u_scale_frac (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (v3_reg),
        .a          (f0_reg),
        .b_exp      (E6_EXP),
        .b_man      (E6_MAN),
        .bypass     (1'b0),
        .tag        (tag3_reg),
        .prod_valid (v4),
        .prod       (f1),
        .prod_tag   (tag4)
    );

    // ---- D1: fraction to fixed point, 72 fraction bits
    logic [FFIX_W-1:0] ffix_next, ffix5_reg;
    logic [4:0]        fsh_amt;
    logic              fsgn5_reg;
    tag_t              tag5_reg;
    logic              v5_reg;

    assign fsh_amt   = 5'(f1.exp + EXP_W'(E6_SHIFT));
    assign ffix_next = f1.zero ? '0 : (FFIX_W'(f1.man) << fsh_amt);

    // ---- D2: exact sum with the units digit
    logic signed [SUM_W-1:0] lead_fix, fext, sum_next, sum6_reg;
    tag_t                    tag6_reg;
    logic                    v6_reg;

    assign lead_fix = SUM_W'(tag5_reg.lead) << FIX_FRAC;
    assign fext     = SUM_W'(ffix5_reg);
    assign sum_next = fsgn5_reg ? (lead_fix - fext) : (lead_fix + fext);

    // ---- D3: sign and magnitude
    logic              dsgn_next, dsgn7_reg;
    logic [SUM_W-1:0]  dabs;
    logic [MAG_W-1:0]  dmag7_reg;
    tag_t              tag7_reg;
    logic              v7_reg;

    assign dsgn_next = sum6_reg[SUM_W-1];
    assign dabs      = dsgn_next ? SUM_W'(-sum6_reg) : SUM_W'(sum6_reg);

    // ---- D4: leading-zero count
    logic [MLZ_W-1:0] dlz8_reg;
    logic [MAG_W-1:0] dmag8_reg;
    logic             dsgn8_reg;
    tag_t             tag8_reg;
    logic             v8_reg;

    // ---- D5: normalize, pick guard and sticky
    logic [MAG_W-1:0]        dsh;
    logic [MAN_W-1:0]        dman9_reg;
    logic                    dg9_reg, ds9_reg, dsgn9_reg, dzero9_reg;
    logic signed [EXP_W-1:0] dexp9_reg;
    tag_t                    tag9_reg;
    logic                    v9_reg;

    assign dsh = dmag8_reg << dlz8_reg;

    // ---- D6: round to nearest even
    logic [MAN_W:0] drnd;
    logic           dinc;
    fp_t            d_next, d_reg;
    tag_t           tag10_reg;
    logic           v10_reg;

    always_comb
    begin
        dinc        = dg9_reg & (ds9_reg | dman9_reg[0]);
        drnd        = (MAN_W+1)'(dman9_reg) + (MAN_W+1)'(dinc);
        d_next.sgn  = dsgn9_reg;
        d_next.zero = dzero9_reg;
        d_next.exp  = dexp9_reg + EXP_W'(drnd[MAN_W]);
        d_next.man  = drnd[MAN_W] ? drnd[MAN_W:1] : drnd[MAN_W-1:0];
    end

    // ---- exponent steps: each multiplies by 10.0 or 0.1, or passes through
    fp_t  step_fp  [STEPS+1];
    tag_t step_tag [STEPS+1];
    logic step_v   [STEPS+1];

    assign step_fp[0]  = d_reg;
    assign step_tag[0] = tag10_reg;
    assign step_v[0]   = v10_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        erfp_fmul u_scale (
            .clk        (clk),
            .rst_n      (rst_n),
            .valid      (step_v[k]),
            .a          (step_fp[k]),
            .b_exp      (step_tag[k].up ? TEN_EXP : TENTH_EXP),
            .b_man      (step_tag[k].up ? TEN_MAN : TENTH_MAN),
            .bypass     (step_tag[k].count <= CNT_W'(k)),
            .tag        (step_tag[k]),
            .prod_valid (step_v[k+1]),
            .prod       (step_fp[k+1]),
            .prod_tag   (step_tag[k+1])
        );
    end

    // ---- output: apply leading minus (0.0 - d keeps a zero positive), pack
    fp_t                  fin;
    tag_t                 fin_tag;
    logic [DBL_EXP_W-1:0] fin_bexp;
    result_t              result_next, result_reg;
    logic                 done_reg;

    assign fin      = step_fp[STEPS];
    assign fin_tag  = step_tag[STEPS];
    assign fin_bexp = DBL_EXP_W'(fin.exp) + DBL_EXP_W'(EXP_BIAS);

    always_comb
    begin
        result_next.format_error = fin_tag.err;
        if (fin.zero)
        begin
            result_next.value_bits = '0;
        end
        else
        begin
            result_next.value_bits = {fin.sgn ^ fin_tag.neg, fin_bexp,
                                      fin.man[DBL_FRAC_W-1:0]};
        end
    end

    // ---- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start & !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v5_reg   <= v4;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            done_reg <= step_v[STEPS];
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        fld0_reg   <= field;
        fint1_reg  <= fint_next;
        tag1_reg   <= tag1_next;
        fsgn2_reg  <= fsgn_next;
        fmag2_reg  <= fmag_next;
        flz2_reg   <= lzc_small(fmag_next);
        tag2_reg   <= tag1_reg;
        f0_reg     <= f0_next;
        tag3_reg   <= tag2_reg;
        ffix5_reg  <= ffix_next;
        fsgn5_reg  <= f1.sgn;
        tag5_reg   <= tag4;
        sum6_reg   <= sum_next;
        tag6_reg   <= tag5_reg;
        dsgn7_reg  <= dsgn_next;
        dmag7_reg  <= dabs[MAG_W-1:0];
        tag7_reg   <= tag6_reg;
        dlz8_reg   <= lzc_wide(dmag7_reg);
        dmag8_reg  <= dmag7_reg;
        dsgn8_reg  <= dsgn7_reg;
        tag8_reg   <= tag7_reg;
        dman9_reg  <= dsh[MAG_W-1 -: MAN_W];
        dg9_reg    <= dsh[MAG_W-1-MAN_W];
        ds9_reg    <= |dsh[MAG_W-2-MAN_W:0];
        dsgn9_reg  <= dsgn8_reg;
        dzero9_reg <= (dmag8_reg == '0);
        dexp9_reg  <= EXP_W'(MAG_W - 1 - FIX_FRAC) - EXP_W'(dlz8_reg);
        tag9_reg   <= tag8_reg;
        d_reg      <= d_next;
        tag10_reg  <= tag9_reg;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a transaction at the pipeline depth");

    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.value_bits[62:0] == '0)) |-> !result.value_bits[63])
        else $error("zero result came out negative");

    a_finite: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.value_bits[DBL_EXP_W+DBL_FRAC_W-1:DBL_FRAC_W] != '1))
        else $error("result exponent field all ones");

endmodule

>>> test/endf_real_field_parse_tb.sv
// Testbench for endf_real_field_parse: random and directed ENDF fields checked against a double model.
module endf_real_field_parse_tb;
    import erfp_pkg::*;

    localparam int NUM_RANDOM  = 1580;
    localparam int CALM_TAIL   = 200;      // last transactions sent back to back
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 100;

    // Scoreboard: expected results held in order of acceptance.
    class field_scoreboard;
        result_t pending[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Works out the double that a field converts to, one rounded step at a time.
        function void note_field(field_t f);
            result_t     r;
            logic [7:0]  ch;
            int          frac_sum;
            int          units;
            int          reps;
            real         value;
            logic        bad;
            bad      = 1'b0;
            frac_sum = 0;
            for (int k = 0; k < FRAC_DIGITS; k++)
            begin
                ch = f.fraction_chars[47 - 8*k -: 8];
                if (ch < CH_ZERO || ch > CH_NINE)
                    bad = 1'b1;
                // weights 100000 down to 1; non-digits still weighted by code-48
                frac_sum = frac_sum * 10 + (int'(ch) - 48);
            end
            if (f.lead_digit_char < CH_ZERO || f.lead_digit_char > CH_NINE)
                bad = 1'b1;
            if (f.exp_digit_char < CH_ZERO || f.exp_digit_char > CH_NINE)
                bad = 1'b1;
            units = int'(f.lead_digit_char) - 48;
            reps  = int'(f.exp_digit_char) - 48;
            if (reps < 0)
                reps = 0;
            if (reps > 9)
                reps = 9;
            value = real'(frac_sum) * 1.0E-6;
            value = real'(units) + value;
            for (int k = 0; k < reps; k++)
            begin
                if (f.exp_sign_char == CH_PLUS)
                    value = value * 10.0;
                else
                    value = value * 0.1;
            end
            if (f.sign_char == CH_MINUS)
                value = 0.0 - value;   // keeps +0.0 for a zero field
            r.value_bits   = $realtobits(value);
            r.format_error = bad;
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value_bits=%h format_error=%b",
                             got.value_bits, got.format_error);
                return;
            end
            want = pending.pop_front();
            if (got.value_bits !== want.value_bits || got.format_error !== want.format_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h/%b got %h/%b",
                             want.value_bits, want.format_error,
                             got.value_bits, got.format_error);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    field_t  field;
    logic    done;
    result_t result;

    field_scoreboard sb;
    int              cycles;

    endf_real_field_parse DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .field  (field),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off; every strobe is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("endf_real_field_parse_tb NOT OK");
            $finish;
        end
    end

    // Random digit character.
    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly digits, sometimes any byte at all.
    function automatic logic [7:0] rand_column(int err_pct);
        if ($urandom_range(0, 99) < err_pct)
            return 8'($urandom);
        return rand_digit();
    endfunction

    function automatic field_t rand_field();
        field_t f;
        int     err_pct;
        int     pick;
        // most fields well formed, a few carry stray characters
        err_pct = ($urandom_range(0, 9) == 0) ? 30 : 0;
        pick    = $urandom_range(0, 9);
        if (pick < 4)
            f.sign_char = CH_MINUS;
        else if (pick < 8)
            f.sign_char = " ";
        else
            f.sign_char = 8'($urandom);
        f.lead_digit_char = rand_column(err_pct);
        for (int k = 0; k < FRAC_DIGITS; k++)
            f.fraction_chars[47 - 8*k -: 8] = rand_column(err_pct);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            f.exp_sign_char = CH_PLUS;
        else if (pick < 9)
            f.exp_sign_char = CH_MINUS;
        else
            f.exp_sign_char = 8'($urandom);
        f.exp_digit_char = rand_column(err_pct);
        return f;
    endfunction

    function automatic field_t make_field(logic [7:0] s, logic [7:0] u, logic [47:0] fr,
                                          logic [7:0] es, logic [7:0] ed);
        field_t f;
        f.sign_char       = s;
        f.lead_digit_char = u;
        f.fraction_chars  = fr;
        f.exp_sign_char   = es;
        f.exp_digit_char  = ed;
        return f;
    endfunction

    // Presents one transaction and holds it until accepted. start stays high on return.
    task automatic send_field(field_t f);
        start <= 1'b1;
        field <= f;
        do
            @(posedge clk);
        while (busy);
        sb.note_field(f);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 15))
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        field_t dir[$];
        sb     = new();
        cycles = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        field  = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, both exponent directions, negative zero, stray characters.
        dir.push_back(make_field(" ", "0", "000000", "+", "0"));
        dir.push_back(make_field("-", "0", "000000", "+", "0"));
        dir.push_back(make_field(" ", "9", "999999", "+", "9"));
        dir.push_back(make_field("-", "9", "999999", "-", "9"));
        dir.push_back(make_field(" ", "1", "000000", "-", "9"));
        dir.push_back(make_field(" ", "1", "000001", "+", "1"));
        dir.push_back(make_field("-", "3", "141593", "+", "5"));
        dir.push_back(make_field(" ", "2", "500000", " ", "3"));
        dir.push_back(make_field(" ", "1", "234567", 8'h00, "2"));
        dir.push_back(make_field(8'h00, 8'h00, 48'h0, 8'h00, 8'h00));
        dir.push_back(make_field(8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF));
        dir.push_back(make_field(" ", "/", "000000", "+", "1"));
        dir.push_back(make_field(" ", ":", "999999", "+", "1"));
        dir.push_back(make_field(" ", "5", "12 456", "+", "0"));
        dir.push_back(make_field(" ", "5", "A23456", "-", "1"));
        dir.push_back(make_field(" ", "5", "000000", "+", "/"));  // clamps to zero
        dir.push_back(make_field(" ", "5", "000000", "+", ":"));  // clamps to nine
        dir.push_back(make_field(" ", "5", "000000", "-", "z"));
        dir.push_back(make_field("-", "0", "000000", "-", 8'h00));
        dir.push_back(make_field(" ", 8'hAA, 48'h5555_5555_5555, 8'h55, 8'hAA));
        dir.push_back(make_field(8'h55, 8'h55, 48'hAAAA_AAAA_AAAA, 8'hAA, 8'h55));
        foreach (dir[k])
            send_field(dir[k]);

        // Hold off the sender until the pipeline is empty.
        wait_drained();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_burst();
            send_field(rand_field());
        end

        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("endf_real_field_parse_tb OK");
        else
            $display("endf_real_field_parse_tb NOT OK");
        $finish;
    end
endmodule

>>> endf_real_field_parse.f
hdl/erfp_pkg.sv
hdl/erfp_fmul.sv
hdl/endf_real_field_parse.sv
test/endf_real_field_parse_tb.sv
